[src/sacd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacd_pkg
// Shared constants of the set-associative cache directory: default geometry,
// fixed field widths and request command codes.
// ----------------------------------------------------------------------------
package sacd_pkg;

	localparam int WAYS_DEF       = 4;
	localparam int SETS_DEF       = 64;
	localparam int LINE_BYTES_DEF = 64;
	localparam int ADDR_BITS_DEF  = 32;

	localparam int ADDR_W    = 32;
	localparam int WAY_OUT_W = 2;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

endpackage

[src/sacd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacd_req_if / sacd_rsp_if
// Valid/ready channels of the cache directory: lookup requests in,
// lookup results out. A transfer takes place when valid and ready are high.
// ----------------------------------------------------------------------------
interface sacd_req_if;
	import sacd_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] addr;

	modport source (output valid, output cmd, output addr, input ready);
	modport sink   (input valid, input cmd, input addr, output ready);
endinterface

interface sacd_rsp_if;
	import sacd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way;
	logic                 evict_valid;
	logic                 evict_wb;
	logic [ADDR_W-1:0]    evict_addr;

	modport source (output valid, output hit, output way, output evict_valid,
		output evict_wb, output evict_addr, input ready);
	modport sink   (input valid, input hit, input way, input evict_valid,
		input evict_wb, input evict_addr, output ready);
endinterface

[src/set_assoc_cache_directory_lru.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_directory_lru
// Tag directory of a set-associative cache with LRU replacement and write
// allocation. Tags live in one memory, valid/dirty/recency in another.
//
//   channel  dir  payload                                     role
//   req      in   cmd, addr                                   lookup request
//   rsp      out  hit, way, evict_valid, evict_wb, evict_addr lookup result
//
// A request first reads the set from both memories into registers; it then
// compares tags, updates recency and writes the set back.
// After reset a clearing pass writes every set of the state memory, during
// which req.ready is low.
// The result sits in an output register; a new request is taken while it
// waits. A request that finishes while the register is still full holds.
// SETS and LINE_BYTES must be powers of two; the block does not check this.
// ----------------------------------------------------------------------------
module set_assoc_cache_directory_lru #(
	parameter int WAYS       = sacd_pkg::WAYS_DEF,
	parameter int SETS       = sacd_pkg::SETS_DEF,
	parameter int LINE_BYTES = sacd_pkg::LINE_BYTES_DEF,
	parameter int ADDR_BITS  = sacd_pkg::ADDR_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sacd_req_if.sink    req,
	sacd_rsp_if.source  rsp
);
	import sacd_pkg::*;

	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_B   = $clog2(SETS);
	localparam int SI_W    = (SETS > 1) ? SET_B : 1;
	localparam int OFF_W   = $clog2(LINE_BYTES);
	localparam int A_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_RAW = A_W - OFF_W - SET_B;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam logic [ADDR_W-1:0] A_MASK = ADDR_W'((65'd1 << A_W) - 65'd1);

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0]             dirty;
		logic [WAYS-1:0][WAY_W-1:0]  order;
	} meta_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	tag_row_t tag_mem  [SETS];
	meta_t    meta_mem [SETS];

	state_t            state_q;
	logic [SI_W-1:0]   clr_q;

	logic              cmd_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SI_W-1:0]   set_s1;
	tag_row_t          tag_rd_s1;
	meta_t             meta_rd_s1;

	logic                 rsp_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic                 ev_valid_q;
	logic                 ev_dirty_q;
	logic [ADDR_W-1:0]    ev_addr_q;

	logic [ADDR_W-1:0] addr_m;
	logic [ADDR_W-1:0] tag_full;
	logic [SI_W-1:0]   set_in;
	logic [TAG_W-1:0]  tag_in;
	logic              req_fire;
	logic              look_go;

	meta_t             meta_init;
	meta_t             meta_new;
	tag_row_t          tag_new;
	logic              hit;
	logic              any_inv;
	logic [WAY_W-1:0]  found_way;
	logic [WAY_W-1:0]  inv_way;
	logic [WAY_W-1:0]  victim;
	logic [WAY_W-1:0]  upd_way;
	logic [WAY_W-1:0]  pos;
	logic              is_write;
	logic              do_upd;
	logic              ev_valid;
	logic              ev_dirty;
	logic [63:0]       ev_line;
	logic [31:0]       way_x;

	assign addr_m   = req.addr & A_MASK;
	assign set_in   = SI_W'((addr_m >> OFF_W) & ADDR_W'(SETS - 1));
	assign tag_full = addr_m >> (OFF_W + SET_B);
	assign tag_in   = tag_full[TAG_W-1:0];

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign look_go   = (state_q == ST_LOOK) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		meta_init = '0;
		for (int i = 0; i < WAYS; i++) begin
			meta_init.order[i] = WAY_W'(i);
		end
	end

	always_comb begin
		is_write  = (cmd_s1 == CMD_WRITE);
		hit       = 1'b0;
		found_way = '0;
		any_inv   = 1'b0;
		inv_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (meta_rd_s1.valid[w] && tag_rd_s1[w] == tag_s1) begin
				hit       = 1'b1;
				found_way = WAY_W'(w);
			end
			if (!meta_rd_s1.valid[w]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
		victim  = any_inv ? inv_way : meta_rd_s1.order[WAYS-1];
		upd_way = hit ? found_way : victim;
		do_upd  = hit || is_write;

		pos = WAY_W'(WAYS - 1);
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (meta_rd_s1.order[i] == upd_way) begin
				pos = WAY_W'(i);
			end
		end

		meta_new = meta_rd_s1;
		for (int i = 0; i < WAYS; i++) begin
			if (i == 0) begin
				meta_new.order[i] = upd_way;
			end else if (WAY_W'(i) <= pos) begin
				meta_new.order[i] = meta_rd_s1.order[i-1];
			end
		end
		if (hit) begin
			if (is_write) begin
				meta_new.dirty[found_way] = 1'b1;
			end
		end else begin
			meta_new.valid[victim] = 1'b1;
			meta_new.dirty[victim] = 1'b0;
		end

		tag_new         = tag_rd_s1;
		tag_new[victim] = tag_s1;

		ev_valid = !hit && is_write && !any_inv;
		ev_dirty = ev_valid && meta_rd_s1.dirty[victim];
		ev_line  = (64'(tag_rd_s1[victim]) << (OFF_W + SET_B)) | (64'(set_s1) << OFF_W);
		way_x    = do_upd ? 32'(upd_way) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SI_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (look_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
			if (look_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1     <= req.cmd;
			tag_s1     <= tag_in;
			set_s1     <= set_in;
			tag_rd_s1  <= tag_mem[set_in];
			meta_rd_s1 <= meta_mem[set_in];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			meta_mem[clr_q] <= meta_init;
		end else if (look_go && do_upd) begin
			meta_mem[set_s1] <= meta_new;
		end
		if (look_go && !hit && is_write) begin
			tag_mem[set_s1] <= tag_new;
		end
	end

	always_ff @(posedge clk) begin
		if (look_go) begin
			hit_q      <= hit;
			way_q      <= way_x[WAY_OUT_W-1:0];
			ev_valid_q <= ev_valid;
			ev_dirty_q <= ev_dirty;
			ev_addr_q  <= ev_valid ? ev_line[ADDR_W-1:0] : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.way         = way_q;
	assign rsp.evict_valid = ev_valid_q;
	assign rsp.evict_wb    = ev_dirty_q;
	assign rsp.evict_addr  = ev_addr_q;

endmodule

[bench/set_assoc_cache_directory_lru_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_directory_lru_tb
// Self-checking bench for the cache tag directory. Drives read and write
// lookups and keeps a directory model of tags, valid, dirty and LRU order.
// The model works out each expected hit, way and eviction report, and the
// scoreboard compares it with every result transfer. A short directed
// sequence covers misses, fills, hits, and clean and dirty evictions. Random
// traffic follows, mostly on a few hot sets and tags, with random idling on
// both sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module set_assoc_cache_directory_lru_tb;
	import sacd_pkg::*;

	localparam int WAYS       = WAYS_DEF;
	localparam int SETS       = SETS_DEF;
	localparam int LINE_BYTES = LINE_BYTES_DEF;
	localparam int OFS_W      = $clog2(LINE_BYTES);
	localparam int SET_W      = $clog2(SETS);
	localparam int TAG_W      = ADDR_W - OFS_W - SET_W;
	localparam int RAND_ITEMS = 1800;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 200;

	typedef struct {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evict_valid;
		logic                 evict_wb;
		logic [ADDR_W-1:0]    evict_addr;
	} lookup_result_t;

	class cache_dir_scoreboard;
		logic [TAG_W-1:0] tags [SETS][WAYS];
		bit               line_valid [SETS][WAYS];
		bit               line_dirty [SETS][WAYS];
		int               lru_order [SETS][WAYS];
		lookup_result_t   pending_results [$];
		int               n_lookups, n_checked, n_hits, n_evicts, n_dirty_evicts, n_errors;

		function new();
			for (int s = 0; s < SETS; s++)
				for (int w = 0; w < WAYS; w++) begin
					tags[s][w]       = '0;
					line_valid[s][w] = 1'b0;
					line_dirty[s][w] = 1'b0;
					lru_order[s][w]  = w;
				end
		endfunction

		function void promote(int s, int w);
			int pos;
			pos = WAYS - 1;
			for (int i = WAYS - 1; i >= 0; i--)
				if (lru_order[s][i] == w)
					pos = i;
			for (int i = pos; i > 0; i--)
				lru_order[s][i] = lru_order[s][i-1];
			lru_order[s][0] = w;
		endfunction

		function void note_request(cmd_t c, logic [ADDR_W-1:0] a);
			int             s, found, victim;
			logic [TAG_W-1:0] tg;
			lookup_result_t r;
			s = int'(a[OFS_W +: SET_W]);
			tg = a[ADDR_W-1 -: TAG_W];
			r = '{hit: 1'b0, way: '0, evict_valid: 1'b0, evict_wb: 1'b0, evict_addr: '0};
			found = -1;
			for (int w = 0; w < WAYS; w++)
				if (found < 0 && line_valid[s][w] && tags[s][w] == tg)
					found = w;
			if (found >= 0) begin
				r.hit = 1'b1;
				r.way = found[WAY_OUT_W-1:0];
				if (c == CMD_WRITE)
					line_dirty[s][found] = 1'b1;
				promote(s, found);
				n_hits++;
			end else if (c == CMD_WRITE) begin
				victim = -1;
				for (int w = 0; w < WAYS; w++)
					if (victim < 0 && !line_valid[s][w])
						victim = w;
				if (victim < 0) begin
					victim = lru_order[s][WAYS-1];
					r.evict_valid = 1'b1;
					r.evict_wb = line_dirty[s][victim];
					r.evict_addr = {tags[s][victim], s[SET_W-1:0], {OFS_W{1'b0}}};
					n_evicts++;
					if (line_dirty[s][victim])
						n_dirty_evicts++;
				end
				tags[s][victim]       = tg;
				line_valid[s][victim] = 1'b1;
				line_dirty[s][victim] = 1'b0;
				promote(s, victim);
				r.way = victim[WAY_OUT_W-1:0];
			end
			pending_results.push_back(r);
			n_lookups++;
		endfunction

		function void check_result(lookup_result_t act);
			lookup_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result transfer with no lookup outstanding");
				n_errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			n_checked++;
			if (act.hit !== exp_r.hit) begin
				$error("hit: expected %0d, got %0d", exp_r.hit, act.hit);
				n_errors++;
			end
			if (act.way !== exp_r.way) begin
				$error("way: expected %0d, got %0d", exp_r.way, act.way);
				n_errors++;
			end
			if (act.evict_valid !== exp_r.evict_valid) begin
				$error("evict_valid: expected %0d, got %0d", exp_r.evict_valid,
					act.evict_valid);
				n_errors++;
			end
			if (act.evict_wb !== exp_r.evict_wb) begin
				$error("evict_wb: expected %0d, got %0d", exp_r.evict_wb,
					act.evict_wb);
				n_errors++;
			end
			if (act.evict_addr !== exp_r.evict_addr) begin
				$error("evict_addr: expected %h, got %h", exp_r.evict_addr, act.evict_addr);
				n_errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sacd_req_if req_ch ();
	sacd_rsp_if rsp_ch ();

	set_assoc_cache_directory_lru DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cache_dir_scoreboard sb = new();

	int               sent_count;
	int               hot_sets [4];
	logic [TAG_W-1:0] tag_pool [6];

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tg, int s,
		int ofs);
		return {tg, s[SET_W-1:0], ofs[OFS_W-1:0]};
	endfunction

	task automatic send_req(input cmd_t c, input logic [ADDR_W-1:0] a);
		bit calm;
		calm = (sent_count >= 1000 && sent_count < 1300);
		while (!calm && $urandom_range(99) < 22) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.addr  <= a;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(c, a);
		sent_count++;
	endtask

	task automatic run_directed();
		for (int t = 1; t <= 4; t++)
			send_req(CMD_WRITE, line_addr(TAG_W'(t), 5, 0));
		send_req(CMD_READ, 32'h0000_0000);
		send_req(CMD_WRITE, 32'h0000_0000);
		send_req(CMD_READ, 32'h0000_003F);
		send_req(CMD_WRITE, 32'hFFFF_FFFF);
		send_req(CMD_READ, 32'hFFFF_FFC0);
		send_req(CMD_WRITE, line_addr(TAG_W'(2), 5, 17));
		send_req(CMD_READ, line_addr(TAG_W'(1), 5, 63));
		send_req(CMD_READ, line_addr(TAG_W'(9), 5, 0));
		send_req(CMD_WRITE, line_addr(TAG_W'(5), 5, 0));
		send_req(CMD_WRITE, line_addr(TAG_W'(6), 5, 0));
		send_req(CMD_WRITE, line_addr(TAG_W'(7), 5, 0));
		send_req(CMD_WRITE, line_addr(TAG_W'(8), 5, 0));
		send_req(CMD_WRITE, line_addr('1, 5, 0));
		send_req(CMD_READ, line_addr('1, 5, 0));
		send_req(CMD_WRITE, 32'hFFFF_FFFF);
		send_req(CMD_READ, 32'h5555_5555);
		send_req(CMD_WRITE, 32'hAAAA_AAAA);
	endtask

	task automatic run_random();
		logic [ADDR_W-1:0] a;
		cmd_t              c;
		for (int i = 0; i < 4; i++)
			hot_sets[i] = $urandom_range(SETS - 1);
		hot_sets[3] = SETS - 1;
		for (int i = 0; i < 6; i++)
			tag_pool[i] = TAG_W'($urandom);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			c = cmd_t'($urandom_range(1));
			if ($urandom_range(99) < 80)
				a = line_addr(tag_pool[$urandom_range(5)], hot_sets[$urandom_range(3)],
					$urandom_range(LINE_BYTES - 1));
			else
				a = $urandom;
			send_req(c, a);
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd   <= CMD_READ;
		req_ch.addr  <= '0;
		sent_count   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		req_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d lookups: %0d hits, %0d evictions, %0d of them dirty",
			sb.n_lookups, sb.n_hits, sb.n_evicts, sb.n_dirty_evicts);
		$display("checked %0d results, %0d field errors", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hold the output once for a long stretch so the block backs up
	initial begin
		int  hold_left;
		bit  held_once;
		lookup_result_t act;
		hold_left = 0;
		held_once = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				act.hit         = rsp_ch.hit;
				act.way         = rsp_ch.way;
				act.evict_valid = rsp_ch.evict_valid;
				act.evict_wb    = rsp_ch.evict_wb;
				act.evict_addr  = rsp_ch.evict_addr;
				sb.check_result(act);
			end
			if (!held_once && sb.n_checked >= 700) begin
				held_once = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (sb.n_checked >= 1000 && sb.n_checked < 1300) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
